// ----- src/wwpb_pkg.sv -----
// Package for the window weighted pixel blend block.
// Holds shared constants, register indexes and the per-window blend factor tables.
// No dependencies.
package wwpb_pkg;

  localparam int PIXEL_BITS_DEFAULT = 10;

  localparam int RATIO_BITS = 7;
  localparam int WS_BITS = 3;
  localparam int IDX_BITS = 2;
  localparam int FACTOR_BITS = 5;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [RATIO_BITS-1:0] RATIO_FULL = 7'd64;
  localparam logic [RATIO_BITS-1:0] RATIO_RESET = 7'd32;
  localparam logic [FACTOR_BITS-1:0] FACTOR_FULL = 5'd16;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_RATIO_WIN2 = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RATIO_WIN3 = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RATIO_WIN4 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RATIO_WIN5 = 2'd3;

  // Window size codes.
  localparam logic [WS_BITS-1:0] WS_2X2 = 3'd2;
  localparam logic [WS_BITS-1:0] WS_3X3 = 3'd3;
  localparam logic [WS_BITS-1:0] WS_4X4 = 3'd4;

  typedef logic [RATIO_BITS-1:0] ratio_t;
  typedef logic [FACTOR_BITS-1:0] factor_t;

  // Source blend factor for the first average, out of 16.
  function automatic factor_t first_factor(input logic [WS_BITS-1:0] ws);
    factor_t f;
    unique case (ws)
      WS_2X2:  f = 5'd0;
      WS_3X3:  f = 5'd4;
      WS_4X4:  f = 5'd16;
      default: f = 5'd4;
    endcase
    return f;
  endfunction

  // Source blend factor for the second average, out of 16.
  function automatic factor_t second_factor(input logic [WS_BITS-1:0] ws);
    factor_t f;
    unique case (ws)
      WS_2X2:  f = 5'd4;
      WS_3X3:  f = 5'd4;
      WS_4X4:  f = 5'd4;
      default: f = 5'd0;
    endcase
    return f;
  endfunction

endpackage

// ----- src/window_weighted_pixel_blend_top.sv -----
// Top level of the window weighted pixel blend block: a four-stage pixel pipeline.
// Depends on wwpb_pkg for constants, register indexes and factor tables.
//
// Usage:
// Pixels enter on the s_* stream channel and leave on the m_* stream channel,
// one result per input transfer. s_tdata carries the two window averages, the
// two averages from the row above and the source pixel; s_tuser carries the
// window size code; s_tlast marks the last pixel of a line and comes out
// unchanged on m_tlast. The four ratio registers are written through
// cfg_we / cfg_index / cfg_data, one register per cycle with cfg_we high.
// m_tvalid rises once a result has passed the four register stages (select,
// upper-row mix, source mix, final weighting). Throughput is one pixel per
// clock while m_tready is high; each stage takes a new pixel every cycle
// unless it is held by a waiting result further down.
// Reset empties the pipeline and sets every ratio register to 32.
// When the receiver holds m_tready low, stages fill up behind the waiting
// result and s_tready drops only once all four stages hold a pixel; nothing
// is lost or repeated.
module window_weighted_pixel_blend_top #(
  parameter int PIXEL_BITS = wwpb_pkg::PIXEL_BITS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // Configuration write port.
  input  logic                                    cfg_we,
  input  logic [wwpb_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [wwpb_pkg::RATIO_BITS-1:0]         cfg_data,
  // Input stream.
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // From bit 0: first_average, second_average, upper_first_average,
  // upper_second_average, source_pixel, zero fill.
  input  logic [((5*PIXEL_BITS+7)/8)*8-1:0]       s_tdata,
  // window_size.
  input  logic [wwpb_pkg::WS_BITS-1:0]            s_tuser,
  input  logic                                    s_tlast,
  // Output stream.
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // From bit 0: blended_pixel, zero fill.
  output logic [((PIXEL_BITS+7)/8)*8-1:0]         m_tdata,
  output logic                                    m_tlast
);
  import wwpb_pkg::*;

  localparam int P = PIXEL_BITS;
  localparam int OUT_W = ((PIXEL_BITS+7)/8)*8;
  localparam int MIX_W = P + RATIO_BITS;
  localparam int SRC_W = P + FACTOR_BITS;
  localparam int FIN_W = P + 4;

  // Ratio registers.
  ratio_t ratio [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) ratio[i] <= RATIO_RESET;
    end else if (cfg_we) begin
      ratio[cfg_index] <= cfg_data;
    end
  end

  // Stage handshake: a stage loads when it is empty or its content moves on.
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4 = !v4 || m_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Stage 1: capture the pixel, select the ratio and the blend factors.
  logic [P-1:0] s1_a0, s1_a1, s1_u0, s1_u1, s1_src;
  ratio_t s1_ratio;
  factor_t s1_f0, s1_f1;
  logic [IDX_BITS-1:0] s1_idx;
  logic s1_last;

  logic [IDX_BITS-1:0] in_idx;
  ratio_t in_ratio;

  assign in_idx = IDX_BITS'(s_tuser - 3'd2);
  // Register values above 64 act as 64.
  assign in_ratio = (ratio[in_idx] > RATIO_FULL) ? RATIO_FULL : ratio[in_idx];

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_a0 <= s_tdata[P-1:0];
      s1_a1 <= s_tdata[2*P-1:P];
      s1_u0 <= s_tdata[3*P-1:2*P];
      s1_u1 <= s_tdata[4*P-1:3*P];
      s1_src <= s_tdata[5*P-1:4*P];
      s1_ratio <= in_ratio;
      s1_f0 <= first_factor(s_tuser);
      s1_f1 <= second_factor(s_tuser);
      s1_idx <= in_idx;
      s1_last <= s_tlast;
    end
  end

  // Stage 2: mix each average with its upper-row average, out of 64.
  logic [MIX_W-1:0] mix0_sum, mix1_sum;
  ratio_t ratio_rest;
  logic [P-1:0] s2_m0, s2_m1, s2_src;
  factor_t s2_f0, s2_f1;
  logic [IDX_BITS-1:0] s2_idx;
  logic s2_last;

  assign ratio_rest = RATIO_FULL - s1_ratio;
  assign mix0_sum = MIX_W'(s1_ratio) * MIX_W'(s1_a0)
                  + MIX_W'(ratio_rest) * MIX_W'(s1_u0) + MIX_W'(32);
  assign mix1_sum = MIX_W'(s1_ratio) * MIX_W'(s1_a1)
                  + MIX_W'(ratio_rest) * MIX_W'(s1_u1) + MIX_W'(32);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_m0 <= mix0_sum[P+5:6];
      s2_m1 <= mix1_sum[P+5:6];
      s2_src <= s1_src;
      s2_f0 <= s1_f0;
      s2_f1 <= s1_f1;
      s2_idx <= s1_idx;
      s2_last <= s1_last;
    end
  end

  // Stage 3: mix each result with the source pixel, out of 16.
  logic [SRC_W-1:0] blend0_sum, blend1_sum;
  factor_t f0_rest, f1_rest;
  logic [P-1:0] s3_b0, s3_b1;
  logic [IDX_BITS-1:0] s3_idx;
  logic s3_last;

  assign f0_rest = FACTOR_FULL - s2_f0;
  assign f1_rest = FACTOR_FULL - s2_f1;
  assign blend0_sum = SRC_W'(s2_m0) * SRC_W'(s2_f0)
                    + SRC_W'(s2_src) * SRC_W'(f0_rest) + SRC_W'(8);
  assign blend1_sum = SRC_W'(s2_m1) * SRC_W'(s2_f1)
                    + SRC_W'(s2_src) * SRC_W'(f1_rest) + SRC_W'(8);

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_b0 <= blend0_sum[P+3:4];
      s3_b1 <= blend1_sum[P+3:4];
      s3_idx <= s2_idx;
      s3_last <= s2_last;
    end
  end

  // Stage 4: weights 2i+1 and 7-2i, out of 8.
  logic [2:0] w0, w1;
  logic [FIN_W-1:0] final_sum;
  logic [P-1:0] s4_res;
  logic s4_last;

  assign w0 = {s3_idx, 1'b1};
  assign w1 = 3'd7 - {s3_idx, 1'b0};
  assign final_sum = FIN_W'(s3_b0) * FIN_W'(w0) + FIN_W'(s3_b1) * FIN_W'(w1) + FIN_W'(4);

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_res <= final_sum[P+2:3];
      s4_last <= s3_last;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata = OUT_W'(s4_res);
  assign m_tlast = s4_last;

endmodule
